// ----- src/rc5_pkg.sv -----
// rc5 cipher package: request codes, sequencer states and the control bundle
// shared by the key store, the round datapath and the top level
// depends on nothing
package rc5_pkg;

  localparam int WORD_W    = 32;
  localparam int BLOCK_W   = 64;
  localparam int KEY_IDX_W = 7;
  localparam int ROUND_W   = 6;
  localparam int PAIR_W    = 6;
  localparam int REQ_W     = 2;

  // largest round count applied, higher settings saturate here
  localparam logic [ROUND_W-1:0] MAX_ROUNDS = 6'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ENCRYPT = 2'd1,
    REQ_DECRYPT = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // datapath control from the sequencer
  typedef struct packed {
    logic load;     // take a fresh block
    logic step;     // apply one round or the whitening
    logic whiten;   // this step is the key whitening
    logic decrypt;  // inverse direction
  } dp_ctrl_t;

endpackage

// ----- src/rc5_in_if.sv -----
// input channel of the rc5 cipher: valid/ready plus one request item
// depends on nothing
interface rc5_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  key_index;
  logic [31:0] key_word;
  logic [63:0] block_in;

  modport source (output valid, output req_type, output key_index, output key_word,
                  output block_in, input ready);
  modport sink   (input valid, input req_type, input key_index, input key_word,
                  input block_in, output ready);
endinterface

// ----- src/rc5_out_if.sv -----
// result channel of the rc5 cipher: valid/ready plus one processed block
// depends on nothing
interface rc5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;

  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

// ----- src/rc5_ram.sv -----
// generic single write port, single read port ram with registered read data
// depends on nothing
module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 34,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/rc5_key_store.sv -----
// round key table split into an even-word bank and an odd-word bank so that
// both keys of one round come out in the same cycle; entries past the table read as zero
// depends on rc5_pkg and rc5_ram
module rc5_key_store #(
  parameter int KEY_TABLE_DEPTH = 68
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [rc5_pkg::KEY_IDX_W-1:0]   wr_idx,
  input  logic [rc5_pkg::WORD_W-1:0]      wr_word,
  input  logic                            rd_en,
  input  logic [rc5_pkg::PAIR_W-1:0]      rd_pair,
  output logic [rc5_pkg::WORD_W-1:0]      key_even,
  output logic [rc5_pkg::WORD_W-1:0]      key_odd
);

  localparam int EVEN_D = (KEY_TABLE_DEPTH + 1) / 2;
  localparam int ODD_D  = KEY_TABLE_DEPTH / 2;
  localparam int EAW    = (EVEN_D > 1) ? $clog2(EVEN_D) : 1;
  localparam int OAW    = (ODD_D > 1) ? $clog2(ODD_D) : 1;
  localparam logic [rc5_pkg::KEY_IDX_W-1:0] DEPTH_K = rc5_pkg::KEY_IDX_W'(KEY_TABLE_DEPTH);

  logic                          wr_ok;
  logic [rc5_pkg::PAIR_W-1:0]    wr_row;
  logic                          even_ok_r;
  logic                          odd_ok_r;
  logic [rc5_pkg::WORD_W-1:0]    even_q;
  logic [rc5_pkg::WORD_W-1:0]    odd_q;

  // loads beyond the table are dropped, bit 0 of the index picks the bank
  assign wr_ok  = wr_en && (wr_idx < DEPTH_K);
  assign wr_row = wr_idx[rc5_pkg::KEY_IDX_W-1:1];

  rc5_ram #(.WIDTH(rc5_pkg::WORD_W), .DEPTH(EVEN_D)) u_even (
    .clk   (clk),
    .we    (wr_ok && !wr_idx[0]),
    .waddr (wr_row[EAW-1:0]),
    .wdata (wr_word),
    .re    (rd_en),
    .raddr (rd_pair[EAW-1:0]),
    .rdata (even_q)
  );

  rc5_ram #(.WIDTH(rc5_pkg::WORD_W), .DEPTH(ODD_D)) u_odd (
    .clk   (clk),
    .we    (wr_ok && wr_idx[0]),
    .waddr (wr_row[OAW-1:0]),
    .wdata (wr_word),
    .re    (rd_en),
    .raddr (rd_pair[OAW-1:0]),
    .rdata (odd_q)
  );

  // remember whether each word of the pair lies inside the table
  always_ff @(posedge clk) begin
    if (rd_en) begin
      even_ok_r <= ({rd_pair, 1'b0} < DEPTH_K);
      odd_ok_r  <= ({rd_pair, 1'b1} < DEPTH_K);
    end
  end

  assign key_even = even_ok_r ? even_q : '0;
  assign key_odd  = odd_ok_r  ? odd_q  : '0;

endmodule

// ----- src/rc5_datapath.sv -----
// word registers A and B with one full rc5 round (or the whitening) per step,
// in either direction
// depends on rc5_pkg
module rc5_datapath (
  input  logic                          clk,
  input  rc5_pkg::dp_ctrl_t             ctrl,
  input  logic [rc5_pkg::BLOCK_W-1:0]   blk_in,
  input  logic [rc5_pkg::WORD_W-1:0]    key_even,
  input  logic [rc5_pkg::WORD_W-1:0]    key_odd,
  output logic [rc5_pkg::BLOCK_W-1:0]   blk_out
);

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} >> s;
    return w[31:0];
  endfunction

  logic [rc5_pkg::WORD_W-1:0] a_r, b_r;
  logic [rc5_pkg::WORD_W-1:0] a_nxt, b_nxt;
  logic [rc5_pkg::WORD_W-1:0] ea, eb, da, db;

  // forward round: A first, then B from the new A
  assign ea = rotl(a_r ^ b_r, b_r[4:0]) + key_even;
  assign eb = rotl(b_r ^ ea, ea[4:0]) + key_odd;

  // inverse round: B first, then A from the new B
  assign db = rotr(b_r - key_odd, a_r[4:0]) ^ a_r;
  assign da = rotr(a_r - key_even, db[4:0]) ^ db;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    priority if (ctrl.load) begin
      a_nxt = blk_in[31:0];
      b_nxt = blk_in[63:32];
    end else if (ctrl.step && ctrl.whiten && !ctrl.decrypt) begin
      a_nxt = a_r + key_even;
      b_nxt = b_r + key_odd;
    end else if (ctrl.step && ctrl.whiten) begin
      a_nxt = a_r - key_even;
      b_nxt = b_r - key_odd;
    end else if (ctrl.step && !ctrl.decrypt) begin
      a_nxt = ea;
      b_nxt = eb;
    end else if (ctrl.step) begin
      a_nxt = da;
      b_nxt = db;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign blk_out = {b_r, a_r};

endmodule

// ----- src/rc5_block_cipher_core.sv -----
// rc5-32 block cipher top level: sequencer, round count register, output register
// depends on rc5_pkg, rc5_in_if, rc5_out_if, rc5_key_store, rc5_datapath
//
//   port       dir  kind               carries
//   in_ch      in   valid/ready item   req_type, key_index, key_word, block_in
//   out_ch     out  valid/ready item   block_out
//   cfg_we/..  in   write strobe       round_count (6 bits)
//
// a load item is taken in the idle state and the block is ready again at once
// an encrypt or decrypt item (r the saturated round count) needs one key-bank read
// ahead, r + 1 round steps at one per cycle, then the load of the output
// register; the single read port of each key bank sets the round pace
// the finished block waits in the output register; a new item is taken meanwhile
// and waits after its last step only if that register is still full
// rst_n is synchronous and clears the sequencer and output valid, not the key table
module rc5_block_cipher_core #(
  parameter int KEY_TABLE_DEPTH = 68
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rc5_in_if.sink                        in_ch,
  rc5_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rc5_pkg::ROUND_W-1:0]   cfg_wdata
);

  rc5_pkg::state_t                state_r, state_nxt;
  logic [rc5_pkg::PAIR_W-1:0]     pair_r, pair_nxt;
  logic [rc5_pkg::ROUND_W-1:0]    rnd_r, rnd_nxt;
  logic                           dec_r, dec_nxt;
  logic [rc5_pkg::ROUND_W-1:0]    rounds_r;
  logic [rc5_pkg::ROUND_W-1:0]    rounds_sat;
  logic                           out_valid_r;
  logic [rc5_pkg::BLOCK_W-1:0]    out_block_r;
  logic                           out_load;
  logic                           accept;
  logic                           last_step;
  logic                           key_wr;
  logic                           rd_en;
  logic [rc5_pkg::PAIR_W-1:0]     rd_pair;
  logic [rc5_pkg::WORD_W-1:0]     key_even, key_odd;
  logic [rc5_pkg::BLOCK_W-1:0]    dp_block;
  rc5_pkg::dp_ctrl_t              ctrl;

  assign in_ch.ready = (state_r == rc5_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rounds_sat  = (rounds_r > rc5_pkg::MAX_ROUNDS) ? rc5_pkg::MAX_ROUNDS : rounds_r;
  assign last_step   = dec_r ? (pair_r == '0) : (pair_r == rnd_r);

  // round count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r <= rc5_pkg::MAX_ROUNDS;
    end else if (cfg_we) begin
      rounds_r <= cfg_wdata;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc5_pkg::ST_IDLE;
      pair_r  <= '0;
      rnd_r   <= '0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pair_r  <= pair_nxt;
      rnd_r   <= rnd_nxt;
      dec_r   <= dec_nxt;
    end
  end

  // next state, key reads and datapath control
  always_comb begin
    state_nxt    = state_r;
    pair_nxt     = pair_r;
    rnd_nxt      = rnd_r;
    dec_nxt      = dec_r;
    key_wr       = 1'b0;
    rd_en        = 1'b0;
    rd_pair      = pair_r;
    out_load     = 1'b0;
    ctrl         = '0;
    ctrl.decrypt = dec_r;
    ctrl.whiten  = (pair_r == '0);
    unique case (state_r)
      rc5_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (rc5_pkg::req_t'(in_ch.req_type))
            rc5_pkg::REQ_LOAD: begin
              key_wr = 1'b1;
            end
            rc5_pkg::REQ_ENCRYPT: begin
              ctrl.load = 1'b1;
              rd_en     = 1'b1;
              rd_pair   = '0;
              pair_nxt  = '0;
              rnd_nxt   = rounds_sat;
              dec_nxt   = 1'b0;
              state_nxt = rc5_pkg::ST_RUN;
            end
            rc5_pkg::REQ_DECRYPT: begin
              ctrl.load = 1'b1;
              rd_en     = 1'b1;
              rd_pair   = rounds_sat;
              pair_nxt  = rounds_sat;
              rnd_nxt   = rounds_sat;
              dec_nxt   = 1'b1;
              state_nxt = rc5_pkg::ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      rc5_pkg::ST_RUN: begin
        ctrl.step = 1'b1;
        if (last_step) begin
          state_nxt = rc5_pkg::ST_DONE;
        end else begin
          rd_en    = 1'b1;
          rd_pair  = dec_r ? (pair_r - 1'b1) : (pair_r + 1'b1);
          pair_nxt = rd_pair;
        end
      end
      rc5_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = rc5_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rc5_pkg::ST_IDLE;
      end
    endcase
  end

  rc5_key_store #(.KEY_TABLE_DEPTH(KEY_TABLE_DEPTH)) u_keys (
    .clk      (clk),
    .wr_en    (key_wr),
    .wr_idx   (in_ch.key_index),
    .wr_word  (in_ch.key_word),
    .rd_en    (rd_en),
    .rd_pair  (rd_pair),
    .key_even (key_even),
    .key_odd  (key_odd)
  );

  rc5_datapath u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .blk_in   (in_ch.block_in),
    .key_even (key_even),
    .key_odd  (key_odd),
    .blk_out  (dp_block)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_block_r <= dp_block;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.block_out = out_block_r;

endmodule

// ----- src/rc5_checker.sv -----
// port-level checks for the rc5 cipher top level, bound onto every instance
// depends on rc5_pkg and rc5_block_cipher_core
module rc5_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready
);

  logic cipher_acc;
  logic load_acc;

  assign cipher_acc = in_valid && in_ready &&
                      ((in_req_type == rc5_pkg::REQ_ENCRYPT) ||
                       (in_req_type == rc5_pkg::REQ_DECRYPT));
  assign load_acc   = in_valid && in_ready && (in_req_type == rc5_pkg::REQ_LOAD);

  // a block item occupies the core, so the next cycle takes no item
  a_busy_after_cipher: assert property (@(posedge clk) disable iff (!rst_n)
    cipher_acc |=> !in_ready)
    else $error("core ready right after taking a block item");

  // a block cannot be finished in the cycle after it is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    cipher_acc && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after a block item");

  // a key load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc && !out_valid |=> !out_valid)
    else $error("key load produced a result");

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rc5_block_cipher_core rc5_checker u_rc5_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready)
);

// ----- sim/tb_top.sv -----
// testbench for the rc5-32 block cipher core: key table load, directed and random items
// through the valid/ready channels, with an in-bench scoreboard predicting every block
// depends on rc5_pkg, rc5_in_if, rc5_out_if and rc5_block_cipher_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_DEPTH    = 68;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_STALL   = 400;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int N_PHASES     = 9;
  localparam int PHASE_ITEMS  = 150;
  localparam int REPORT_MAX   = 10;

  // request code outside the package set, ignored by the block
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [6:0]  idx;
    logic [31:0] word;
    logic [63:0] blk;
  } cipher_item_t;

  // scoreboard: own copy of the key table and round count, queue of predicted blocks
  class cipher_scoreboard;
    logic [31:0] key_table [KEY_DEPTH];
    logic [5:0]  round_setting;
    logic [63:0] predicted_blocks [$];
    logic [63:0] last_block;
    int          failures;

    function new();
      round_setting = rc5_pkg::MAX_ROUNDS;
      last_block    = '0;
      failures      = 0;
      foreach (key_table[i]) key_table[i] = '0;
    endfunction

    function logic [31:0] key_at(int unsigned idx);
      if (idx >= KEY_DEPTH) return '0;
      return key_table[idx];
    endfunction

    function logic [31:0] rotl(logic [31:0] x, logic [31:0] n);
      logic [63:0] t;
      t = {x, x} << n[4:0];
      return t[63:32];
    endfunction

    function logic [31:0] rotr(logic [31:0] x, logic [31:0] n);
      logic [63:0] t;
      t = {x, x} >> n[4:0];
      return t[31:0];
    endfunction

    function int unsigned active_rounds();
      return (round_setting > rc5_pkg::MAX_ROUNDS) ? rc5_pkg::MAX_ROUNDS : round_setting;
    endfunction

    function logic [63:0] encrypt_block(logic [63:0] blk);
      logic [31:0] a;
      logic [31:0] b;
      int unsigned r;
      r = active_rounds();
      a = blk[31:0] + key_at(0);
      b = blk[63:32] + key_at(1);
      for (int unsigned i = 1; i <= r; i++) begin
        a = rotl(a ^ b, b) + key_at(2 * i);
        b = rotl(b ^ a, a) + key_at(2 * i + 1);
      end
      return {b, a};
    endfunction

    function logic [63:0] decrypt_block(logic [63:0] blk);
      logic [31:0] a;
      logic [31:0] b;
      int unsigned i;
      a = blk[31:0];
      b = blk[63:32];
      for (i = active_rounds(); i > 0; i--) begin
        b = rotr(b - key_at(2 * i + 1), a) ^ a;
        a = rotr(a - key_at(2 * i), b) ^ b;
      end
      b = b - key_at(1);
      a = a - key_at(0);
      return {b, a};
    endfunction

    // accepted input item: update the key table or predict a block
    function void note_input(cipher_item_t it);
      case (it.req)
        rc5_pkg::REQ_LOAD: begin
          if (it.idx < KEY_DEPTH) key_table[it.idx] = it.word;
        end
        rc5_pkg::REQ_ENCRYPT: begin
          last_block = encrypt_block(it.blk);
          predicted_blocks.push_back(last_block);
        end
        rc5_pkg::REQ_DECRYPT: begin
          last_block = decrypt_block(it.blk);
          predicted_blocks.push_back(last_block);
        end
        default: ;
      endcase
    endfunction

    // accepted result item: compare with the oldest prediction
    function void check_result(logic [63:0] got);
      logic [63:0] want;
      if (predicted_blocks.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected block_out %h with nothing predicted", got);
        return;
      end
      want = predicted_blocks.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("block_out mismatch: expected %h actual %h", want, got);
      end
    endfunction

    function int pending();
      return predicted_blocks.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rc5_pkg::ROUND_W-1:0]   cfg_wdata;

  rc5_in_if  in_bus ();
  rc5_out_if out_bus ();

  cipher_scoreboard sb;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int stall_asks      = 0;
  int stall_done      = 0;
  int hold_left       = 0;
  int cycle_count     = 0;
  int phase_rounds [N_PHASES] = '{32, 1, 0, 63, 7, 33, 20, 32, 45};

  rc5_block_cipher_core #(
    .KEY_TABLE_DEPTH(KEY_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side ready: long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_asks != stall_done) begin
      stall_done = stall_asks;
      hold_left = LONG_STALL - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_result(out_bus.block_out);
  end

  function automatic cipher_item_t make_item(logic [1:0] req, logic [6:0] idx,
                                             logic [31:0] word, logic [63:0] blk);
    cipher_item_t it;
    it.req  = req;
    it.idx  = idx;
    it.word = word;
    it.blk  = blk;
    return it;
  endfunction

  function automatic logic [63:0] rand_block();
    return {$urandom(), $urandom()};
  endfunction

  // offer one item after an optional random gap, hold it until accepted
  task automatic send_item(input cipher_item_t it);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.req_type  <= it.req;
    in_bus.key_index <= it.idx;
    in_bus.key_word  <= it.word;
    in_bus.block_in  <= it.blk;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  // stop offering and wait until every predicted block has come out
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // round count write, only with the block idle
  task automatic set_round_count(input logic [5:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.round_setting = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int counted;
    int pick;
    logic [31:0] word;

    sb = new();
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.req_type   = '0;
    in_bus.key_index  = '0;
    in_bus.key_word   = '0;
    in_bus.block_in   = '0;
    out_bus.ready     = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full key table, so no round ever reads an unwritten entry
    for (int i = 0; i < KEY_DEPTH; i++) begin
      if (i == 0) word = 32'h711773be;
      else if (i == 1) word = 32'h1dd61065;
      else if (i == KEY_DEPTH - 2) word = 32'h0;
      else if (i == KEY_DEPTH - 1) word = 32'hffffffff;
      else word = $urandom();
      send_item(make_item(rc5_pkg::REQ_LOAD, i[6:0], word, rand_block()));
    end

    // directed: field extremes at the reset round count
    send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'd0, 32'h0, 64'h0));
    send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'h7f, 32'hffffffff, {64{1'b1}}));
    send_item(make_item(rc5_pkg::REQ_DECRYPT, 7'd0, 32'h0, 64'h0));
    send_item(make_item(rc5_pkg::REQ_DECRYPT, 7'h7f, 32'hffffffff, {64{1'b1}}));
    send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'd5, 32'h0, 64'h00000000_ffffffff));
    send_item(make_item(rc5_pkg::REQ_DECRYPT, 7'd9, 32'h0, sb.last_block));
    // unknown request and loads outside the table are ignored
    send_item(make_item(REQ_UNKNOWN, 7'h7f, 32'hffffffff, {64{1'b1}}));
    send_item(make_item(rc5_pkg::REQ_LOAD, 7'h7f, 32'hffffffff, 64'h0));
    send_item(make_item(rc5_pkg::REQ_LOAD, 7'd68, 32'h12345678, 64'h0));
    send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'd0, 32'h0, 64'hffffffff_00000000));
    // zero rounds: whitening only
    set_round_count(6'd0);
    send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'd0, 32'h0, rand_block()));
    send_item(make_item(rc5_pkg::REQ_DECRYPT, 7'd0, 32'h0, rand_block()));
    send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'd0, 32'h0, {64{1'b1}}));
    // round count above the maximum saturates
    set_round_count(6'd63);
    send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'd0, 32'h0, rand_block()));
    send_item(make_item(rc5_pkg::REQ_DECRYPT, 7'd0, 32'h0, sb.last_block));
    // single round
    set_round_count(6'd1);
    send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'd0, 32'h0, rand_block()));
    send_item(make_item(rc5_pkg::REQ_DECRYPT, 7'd0, 32'h0, rand_block()));

    // random phases over round counts and idling patterns
    phase_rounds[6] = $urandom_range(2, 31);
    phase_rounds[8] = $urandom_range(0, 63);
    for (int p = 0; p < N_PHASES; p++) begin
      set_round_count(phase_rounds[p][5:0]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // long receiver hold-off while items keep coming
        if (p == 0 && counted == 20) stall_asks = stall_asks + 1;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'($urandom()), $urandom(),
                              rand_block()));
          counted++;
        end else if (pick < 68) begin
          send_item(make_item(rc5_pkg::REQ_DECRYPT, 7'($urandom()), $urandom(),
                              rand_block()));
          counted++;
        end else if (pick < 80) begin
          // round trip on the last predicted block
          if (pick < 74)
            send_item(make_item(rc5_pkg::REQ_DECRYPT, 7'($urandom()), $urandom(),
                                sb.last_block));
          else
            send_item(make_item(rc5_pkg::REQ_ENCRYPT, 7'($urandom()), $urandom(),
                                sb.last_block));
          counted++;
        end else if (pick < 92) begin
          send_item(make_item(rc5_pkg::REQ_LOAD, 7'($urandom_range(0, KEY_DEPTH - 1)),
                              $urandom(), rand_block()));
          counted++;
        end else if (pick < 96) begin
          send_item(make_item(rc5_pkg::REQ_LOAD, 7'($urandom_range(KEY_DEPTH, 127)),
                              $urandom(), rand_block()));
        end else begin
          send_item(make_item(REQ_UNKNOWN, 7'($urandom()), $urandom(), rand_block()));
        end
      end
    end

    // end of run: let everything out, then the verdict
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    drain();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
